// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
// Each macro states a clocked property that the active-low reset disables.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/erest_pkg.sv =====
package erest_pkg;

    localparam int NUM_CH        = 2;
    localparam int HISTORY_DEPTH = 10;
    localparam int DATA_W        = 32;
    localparam int STAMP_W       = 32;
    localparam int MIN_DT_W      = 16;
    localparam logic [MIN_DT_W-1:0] MIN_DT_RESET = 16'd10;

    // Microseconds per second, the scale of the finite difference.
    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam int PROD_W = DATA_W + USEC_W;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] RATE_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] RATE_MIN = 32'h8000_0000;

    // Running sum of one history and its serial division by the depth.
    localparam int SUM_W       = DATA_W + $clog2(HISTORY_DEPTH);
    localparam int MEAN_DIGIT  = 4;
    localparam int MEAN_STEPS  = (SUM_W + MEAN_DIGIT - 1) / MEAN_DIGIT;
    localparam int MEAN_W      = MEAN_STEPS * MEAN_DIGIT;
    localparam int MEAN_REM_W  = $clog2(HISTORY_DEPTH + 1) + 1;
    localparam int MEAN_CNT_W  = $clog2(MEAN_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_GO,
        ST_DIV,
        ST_MEAN_GO,
        ST_MEAN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_ITER,
        DV_DONE
    } t_div_state;

    typedef enum logic [1:0] {
        MN_IDLE,
        MN_ITER,
        MN_DONE
    } t_mean_state;

    typedef struct packed {
        logic                start;
        logic [DATA_W-1:0]   mag;
        logic [STAMP_W-1:0]  dt;
    } t_div_cmd;

    typedef struct packed {
        logic                done;
        logic                ovf;
        logic [DATA_W-1:0]   quo;
    } t_div_res;

    typedef struct packed {
        logic                      push;
        logic                      ch;
        logic signed [DATA_W-1:0]  rate;
    } t_hist_cmd;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  sum;
    } t_mean_cmd;

    typedef struct packed {
        logic                      done;
        logic signed [DATA_W-1:0]  value;
    } t_mean_res;

endpackage

// ===== design/erest_divider.sv =====
module erest_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  erest_pkg::t_div_cmd  i_cmd,
    output erest_pkg::t_div_res  o_res
);
    import erest_pkg::*;

    t_div_state               r_state, n_state;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_quo;
    logic [STAMP_W-1:0]       r_dt;
    logic [DIV_CNT_W-1:0]     r_cnt;
    logic                     r_ovf;
    logic [PROD_W-1:0]        prod;
    logic [DATA_W:0]          rem_sh;
    logic [DATA_W:0]          rem_sub;
    logic                     rem_ge;
    logic                     ovf_now;

    // The product is registered split into its high and low words; the
    // low word then shifts out one bit a cycle as the quotient shifts in.
    assign prod    = PROD_W'(i_cmd.mag) * PROD_W'(USEC_PER_SEC);
    assign rem_sh  = {r_rem, r_quo[DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dt};
    assign rem_ge  = !rem_sub[DATA_W];
    // A high word at or above the divisor means a quotient of 2^32 or more.
    assign ovf_now = r_rem >= r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= DATA_W'(prod[PROD_W-1:DATA_W]);
            r_quo <= prod[DATA_W-1:0];
            r_dt  <= i_cmd.dt;
            r_cnt <= '1;
        end else if (r_state == DV_CHECK) begin
            r_ovf <= ovf_now;
        end else if (r_state == DV_ITER) begin
            r_rem <= rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], rem_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: begin
                if (i_cmd.start) begin
                    n_state = DV_CHECK;
                end
            end
            DV_CHECK: begin
                n_state = ovf_now ? DV_DONE : DV_ITER;
            end
            DV_ITER: begin
                if (r_cnt == '0) begin
                    n_state = DV_DONE;
                end
            end
            DV_DONE: begin
                n_state = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.done = (r_state == DV_DONE);
        o_res.ovf  = r_ovf;
        o_res.quo  = r_quo;
    end

endmodule

// ===== design/erest_history.sv =====
module erest_history (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  erest_pkg::t_hist_cmd                i_cmd,
    output logic signed [erest_pkg::SUM_W-1:0]  o_sum
);
    import erest_pkg::*;

    logic signed [DATA_W-1:0] r_hist [NUM_CH][HISTORY_DEPTH];
    logic signed [SUM_W-1:0]  r_sum  [NUM_CH];
    logic signed [SUM_W-1:0]  oldest_ext;
    logic signed [SUM_W-1:0]  rate_ext;
    logic signed [SUM_W-1:0]  n_sum;

    assign oldest_ext = {{(SUM_W-DATA_W){r_hist[i_cmd.ch][0][DATA_W-1]}}, r_hist[i_cmd.ch][0]};
    assign rate_ext   = {{(SUM_W-DATA_W){i_cmd.rate[DATA_W-1]}}, i_cmd.rate};
    assign n_sum      = r_sum[i_cmd.ch] - oldest_ext + rate_ext;
    assign o_sum      = r_sum[i_cmd.ch];

    // Oldest entry sits at index zero and drops out on each push.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                    r_hist[c][i] <= '0;
                end
            end
        end else if (i_cmd.push) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                r_hist[i_cmd.ch][i] <= r_hist[i_cmd.ch][i+1];
            end
            r_hist[i_cmd.ch][HISTORY_DEPTH-1] <= i_cmd.rate;
            r_sum[i_cmd.ch] <= n_sum;
        end
    end

endmodule

// ===== design/erest_mean.sv =====
module erest_mean (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  erest_pkg::t_mean_cmd  i_cmd,
    output erest_pkg::t_mean_res  o_res
);
    import erest_pkg::*;

    t_mean_state              r_state, n_state;
    logic [MEAN_W-1:0]        r_quo;
    logic [MEAN_REM_W-1:0]    r_rem;
    logic [MEAN_CNT_W-1:0]    r_cnt;
    logic                     r_neg;
    logic [SUM_W-1:0]         mag;
    logic [MEAN_W-1:0]        it_quo;
    logic [MEAN_REM_W-1:0]    it_rem;

    assign mag = i_cmd.sum[SUM_W-1] ? SUM_W'(-i_cmd.sum) : SUM_W'(i_cmd.sum);

    // One digit of the quotient per cycle, restoring division by the depth.
    always_comb begin
        it_rem = r_rem;
        it_quo = r_quo;
        for (int k = 0; k < MEAN_DIGIT; k++) begin
            it_rem = {it_rem[MEAN_REM_W-2:0], it_quo[MEAN_W-1]};
            it_quo = {it_quo[MEAN_W-2:0], 1'b0};
            if (it_rem >= MEAN_REM_W'(HISTORY_DEPTH)) begin
                it_rem    = it_rem - MEAN_REM_W'(HISTORY_DEPTH);
                it_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_neg <= i_cmd.sum[SUM_W-1];
            r_quo <= MEAN_W'(mag);
            r_rem <= '0;
            r_cnt <= MEAN_CNT_W'(MEAN_STEPS - 1);
        end else if (r_state == MN_ITER) begin
            r_quo <= it_quo;
            r_rem <= it_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MN_IDLE: begin
                if (i_cmd.start) begin
                    n_state = MN_ITER;
                end
            end
            MN_ITER: begin
                if (r_cnt == '0) begin
                    n_state = MN_DONE;
                end
            end
            MN_DONE: begin
                n_state = MN_IDLE;
            end
            default: begin
                n_state = MN_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.done  = (r_state == MN_DONE);
        o_res.value = r_neg ? (~r_quo[DATA_W-1:0]) + DATA_W'(1) : r_quo[DATA_W-1:0];
    end

endmodule

// ===== design/error_rate_estimator.sv =====
// Rate estimator for two error channels, lateral offset (action 0) and
// heading (action 1). Each item carries a Q16.16 sample and a microsecond
// stamp. When the sample differs from the channel's stored position, the
// block stores the sample and stamp, and if the wrapping time gap is strictly
// greater than min_dt_us it also pushes the finite-difference rate
// (sample - position) * 1e6 / gap, truncated toward zero and saturated to 32
// bits, into a ten-deep history for that channel. Every item returns exactly
// one result: the channel's position after the item, the history mean
// truncated toward zero, and an updated flag. An item that pushes a rate
// passes through evaluation, the bit-serial quotient (one bit a cycle over
// 32 bits) and the four-bit-a-cycle mean before its output; an item whose
// quotient exceeds 32 bits skips the quotient loop; an item with an equal
// sample or a short gap goes from evaluation straight to the output. One
// item is worked at a time; the result sits in an output register, so the
// next item is taken while a result waits, and processing pauses only when
// a second result is ready before the first has left. min_dt_us resets to
// 10; the user must have it written only while the block is idle, since
// the block itself does not enforce this.
`include "assert_macros.svh"

module error_rate_estimator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [erest_pkg::MIN_DT_W-1:0]         i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_action,
    input  logic signed [erest_pkg::DATA_W-1:0]    i_sample,
    input  logic [erest_pkg::STAMP_W-1:0]          i_stamp_us,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [erest_pkg::DATA_W-1:0]    o_position,
    output logic signed [erest_pkg::DATA_W-1:0]    o_rate,
    output logic                                   o_updated
);
    import erest_pkg::*;

    // Control state.
    t_state                    r_state, n_state;
    logic [MIN_DT_W-1:0]       r_min_dt;
    logic                      r_out_valid;

    // Per-channel state; the history itself lives in erest_history.
    logic signed [DATA_W-1:0]  r_last_pos   [NUM_CH];
    logic [STAMP_W-1:0]        r_last_stamp [NUM_CH];
    logic signed [DATA_W-1:0]  r_mean       [NUM_CH];

    // The item in flight and its intermediate values.
    logic                      r_ch;
    logic signed [DATA_W-1:0]  r_sample;
    logic [STAMP_W-1:0]        r_stamp;
    logic [DATA_W-1:0]         r_mag;
    logic [STAMP_W-1:0]        r_dt;
    logic                      r_neg;
    logic                      r_upd;

    // Output register.
    logic signed [DATA_W-1:0]  r_position;
    logic signed [DATA_W-1:0]  r_rate;
    logic                      r_updated;

    logic                      in_accept;
    logic                      out_load;
    logic                      eval_upd;
    logic                      mean_wr;
    logic                      differ;
    logic                      take_rate;
    logic signed [DATA_W:0]    diff;
    logic signed [DATA_W:0]    diff_neg;
    logic [DATA_W-1:0]         diff_mag;
    logic [STAMP_W-1:0]        gap;
    logic signed [DATA_W-1:0]  rate_sat;
    logic signed [SUM_W-1:0]   hist_sum;

    t_div_cmd                  div_cmd;
    t_div_res                  div_res;
    t_hist_cmd                 hist_cmd;
    t_mean_cmd                 mean_cmd;
    t_mean_res                 mean_res;

    erest_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_res   (div_res)
    );

    erest_history u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (hist_cmd),
        .o_sum   (hist_sum)
    );

    erest_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mean_cmd),
        .o_res   (mean_res)
    );

    // Compare against the stored position and measure the gap. The signed
    // difference needs 33 bits, but its magnitude always fits in 32.
    assign differ    = (r_sample != r_last_pos[r_ch]);
    assign diff      = {r_sample[DATA_W-1], r_sample}
                       - {r_last_pos[r_ch][DATA_W-1], r_last_pos[r_ch]};
    assign diff_neg  = -diff;
    assign diff_mag  = diff[DATA_W] ? diff_neg[DATA_W-1:0] : diff[DATA_W-1:0];
    assign gap       = r_stamp - r_last_stamp[r_ch];
    assign take_rate = (gap > STAMP_W'(r_min_dt));

    // Saturate the unsigned quotient back to a signed 32-bit rate. The
    // overflow flag means the quotient reached 2^32 or more.
    always_comb begin
        if (r_neg) begin
            if (div_res.ovf || (div_res.quo > RATE_MIN)) begin
                rate_sat = RATE_MIN;
            end else begin
                rate_sat = (~div_res.quo) + DATA_W'(1);
            end
        end else begin
            if (div_res.ovf || div_res.quo[DATA_W-1]) begin
                rate_sat = RATE_MAX;
            end else begin
                rate_sat = div_res.quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min_dt    <= MIN_DT_RESET;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_last_pos[c]   <= '0;
                r_last_stamp[c] <= '0;
                r_mean[c]       <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_min_dt <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (eval_upd) begin
                r_last_pos[r_ch]   <= r_sample;
                r_last_stamp[r_ch] <= r_stamp;
            end
            if (mean_wr) begin
                r_mean[r_ch] <= mean_res.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch     <= i_action;
            r_sample <= i_sample;
            r_stamp  <= i_stamp_us;
        end
        if (r_state == ST_EVAL) begin
            r_mag <= diff_mag;
            r_dt  <= gap;
            r_neg <= diff[DATA_W];
            r_upd <= differ;
        end
        if (out_load) begin
            r_position <= r_last_pos[r_ch];
            r_rate     <= r_mean[r_ch];
            r_updated  <= r_upd;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (differ && take_rate) begin
                    n_state = ST_DIV_GO;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV_GO: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    n_state = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO: begin
                n_state = ST_MEAN;
            end
            ST_MEAN: begin
                if (mean_res.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs decoded from the state.
    always_comb begin
        o_in_stall     = (r_state != ST_IDLE);
        in_accept      = (r_state == ST_IDLE) && i_in_valid;
        eval_upd       = (r_state == ST_EVAL) && differ;
        out_load       = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
        mean_wr        = (r_state == ST_MEAN) && mean_res.done;

        div_cmd.start  = (r_state == ST_DIV_GO);
        div_cmd.mag    = r_mag;
        div_cmd.dt     = r_dt;

        hist_cmd.push  = (r_state == ST_DIV) && div_res.done;
        hist_cmd.ch    = r_ch;
        hist_cmd.rate  = rate_sat;

        mean_cmd.start = (r_state == ST_MEAN_GO);
        mean_cmd.sum   = hist_sum;
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;
    assign o_rate      = r_rate;
    assign o_updated   = r_updated;

    // An accepted item always moves the controller into evaluation.
    `ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, in_accept, r_state == ST_EVAL)
    // A rate is pushed only for an item whose sample changed the position.
    `ASSERT_SAME(a_push_upd, i_clk, i_rst_n, hist_cmd.push, r_upd)
    // The quotient unit finishes only while the controller waits for it.
    `ASSERT_SAME(a_div_done, i_clk, i_rst_n, div_res.done, r_state == ST_DIV)
    // The mean unit finishes only while the controller waits for it.
    `ASSERT_SAME(a_mean_done, i_clk, i_rst_n, mean_res.done, r_state == ST_MEAN)

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import erest_pkg::*;

    localparam int PHASE_ITEMS    = 350;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int REPORT_LIMIT   = 10;

    // One report of the block, as the model predicts it.
    typedef struct packed {
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] rate;
        logic                     updated;
    } t_report;

    // One row of the directed table.
    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] sample;
        logic [STAMP_W-1:0]       stamp;
        logic                     typed;
        t_report                  want;
    } t_step;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [MIN_DT_W-1:0]       i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_action;
    logic signed [DATA_W-1:0]  i_sample;
    logic [STAMP_W-1:0]        i_stamp_us;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [DATA_W-1:0]  o_position;
    logic signed [DATA_W-1:0]  o_rate;
    logic                      o_updated;

    error_rate_estimator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_sample    (i_sample),
        .i_stamp_us  (i_stamp_us),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_rate      (o_rate),
        .o_updated   (o_updated)
    );

    // Model state. It mirrors what the block holds for each channel.
    logic signed [DATA_W-1:0] est_position [NUM_CH];
    logic [STAMP_W-1:0]       est_stamp    [NUM_CH];
    logic signed [DATA_W-1:0] est_history  [NUM_CH][HISTORY_DEPTH];
    logic signed [SUM_W-1:0]  est_sum      [NUM_CH];
    logic [MIN_DT_W-1:0]      min_gap_us;

    t_report pending_reports[$];
    t_step   directed_steps[$];
    int      fail_count;
    int      report_count;
    int      quiet_cycles;
    bit      calm;

    // The clock has a 4 ns period.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    // Idle lengths: mostly none, often short, rarely a long stretch.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(25, 60);
    endfunction

    // Runs one item through the model and returns the report it causes.
    // A changed sample always moves the position and the stamp. A rate
    // enters the history only when the wrapping gap beats the minimum.
    function automatic t_report advance_channel(input logic ch,
                                                input logic signed [DATA_W-1:0] smp,
                                                input logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0]       gap;
        logic signed [DATA_W:0]   diff;
        logic [63:0]              mag;
        logic [63:0]              quo;
        logic signed [DATA_W-1:0] fresh;
        logic signed [SUM_W-1:0]  mean;
        t_report                  rpt;
        rpt.updated = 1'b0;
        if (smp != est_position[ch]) begin
            gap = stamp - est_stamp[ch];
            if (gap > {{(STAMP_W-MIN_DT_W){1'b0}}, min_gap_us}) begin
                diff = $signed({smp[DATA_W-1], smp})
                     - $signed({est_position[ch][DATA_W-1], est_position[ch]});
                mag = {{(63-DATA_W){1'b0}}, (diff[DATA_W] ? -diff : diff)};
                quo = (mag * 64'(USEC_PER_SEC)) / {32'd0, gap};
                if (diff[DATA_W]) begin
                    // Negative rates clip at the most negative 32-bit value.
                    if (quo > 64'h8000_0000) begin
                        quo = 64'h8000_0000;
                    end
                    fresh = -quo[DATA_W-1:0];
                end else begin
                    if (quo > 64'h7FFF_FFFF) begin
                        quo = 64'h7FFF_FFFF;
                    end
                    fresh = quo[DATA_W-1:0];
                end
                // The oldest entry leaves the sum and the new rate joins it.
                est_sum[ch] = est_sum[ch] - est_history[ch][0] + fresh;
                for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                    est_history[ch][i] = est_history[ch][i + 1];
                end
                est_history[ch][HISTORY_DEPTH-1] = fresh;
            end
            est_position[ch] = smp;
            est_stamp[ch] = stamp;
            rpt.updated = 1'b1;
        end
        // Signed division truncates toward zero, as the block does.
        mean = est_sum[ch] / $signed(SUM_W'(HISTORY_DEPTH));
        rpt.position = est_position[ch];
        rpt.rate = mean[DATA_W-1:0];
        return rpt;
    endfunction

    function automatic void add_step(input logic ch, input logic [DATA_W-1:0] smp,
                                     input logic [STAMP_W-1:0] stamp,
                                     input logic typed,
                                     input logic [DATA_W-1:0] pos,
                                     input logic [DATA_W-1:0] rate,
                                     input logic upd);
        t_step s;
        s.action = ch;
        s.sample = smp;
        s.stamp = stamp;
        s.typed = typed;
        s.want.position = pos;
        s.want.rate = rate;
        s.want.updated = upd;
        directed_steps.insert(directed_steps.size(), s);
    endfunction

    // Builds a random item from the model's current state. Most stamps
    // land just past the minimum gap so that rates get computed. Some
    // land at or below it, some far beyond it, and a few anywhere at all.
    function automatic void make_item(output logic ch,
                                      output logic signed [DATA_W-1:0] smp,
                                      output logic [STAMP_W-1:0] stamp);
        int unsigned k;
        logic [STAMP_W-1:0] m;
        ch = 1'($urandom_range(0, 1));
        m = {{(STAMP_W-MIN_DT_W){1'b0}}, min_gap_us};
        k = $urandom_range(0, 99);
        if (k < 45) begin
            stamp = est_stamp[ch] + m + $urandom_range(1, 2000);
        end else if (k < 60) begin
            stamp = est_stamp[ch] + m + $urandom_range(0, 1);
        end else if (k < 75) begin
            stamp = est_stamp[ch] + $urandom_range(0, m);
        end else if (k < 88) begin
            stamp = est_stamp[ch] + m + $urandom_range(2000, 1000000);
        end else begin
            stamp = $urandom;
        end
        k = $urandom_range(0, 99);
        if (k < 15) begin
            smp = est_position[ch];
        end else if (k < 60) begin
            smp = est_position[ch] + 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        end else if (k < 75) begin
            smp = $urandom;
        end else if (k < 85) begin
            smp = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end else begin
            smp = est_position[ch] + 32'($urandom_range(1, 3));
        end
    endfunction

    // Offers one item and waits until the block takes it. This is entered
    // and left at a falling edge. With no idle cycles between items, valid
    // simply stays high, so it is assigned once in that time step.
    task automatic send_item(input logic ch, input logic signed [DATA_W-1:0] smp,
                             input logic [STAMP_W-1:0] stamp,
                             input logic typed, input t_report want);
        int      idle;
        t_report predicted;
        idle = calm ? 0 : pick_gap();
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= ch;
        i_sample   <= smp;
        i_stamp_us <= stamp;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        // The model runs on every item. Rows with a typed report must match
        // the hand-worked values rather than the model's.
        predicted = advance_channel(ch, smp, stamp);
        pending_reports.insert(pending_reports.size(), typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // The block returns one report per item, so once the queue is empty it
    // has nothing in flight. The extra cycles are only a margin.
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_min_gap(input logic [MIN_DT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        min_gap_us = value;
    endtask

    // Output side. The stall changes only at falling edges. It comes in
    // runs of random length and is held low during calm stretches.
    int stall_hold;
    always @(negedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else if ($urandom_range(0, 99) < 35) begin
            i_out_stall <= 1'b1;
            stall_hold = pick_gap();
        end else begin
            i_out_stall <= 1'b0;
            stall_hold = $urandom_range(1, 8);
        end
    end

    // Each report the block delivers is checked against the oldest one
    // expected.
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            report_count++;
            if (pending_reports.size() == 0) begin
                note_failure($sformatf(
                    "report %0d arrived with none expected: pos %h rate %h upd %b",
                    report_count, o_position, o_rate, o_updated));
            end else begin
                want = pending_reports.pop_front();
                if (o_position !== want.position || o_rate !== want.rate
                        || o_updated !== want.updated) begin
                    note_failure($sformatf(
                        "report %0d: pos exp %h got %h, rate exp %h got %h, upd exp %b got %b",
                        report_count, want.position, o_position, want.rate, o_rate,
                        want.updated, o_updated));
                end
            end
        end
    end

    // Watchdog. It counts cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic                     ch;
        logic signed [DATA_W-1:0] smp;
        logic [STAMP_W-1:0]       stamp;
        logic [MIN_DT_W-1:0]      gap_setting;
        t_report                  none;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_action    = 1'b0;
        i_sample    = '0;
        i_stamp_us  = '0;
        fail_count   = 0;
        report_count = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        none         = '0;

        // Model reset. Everything is zero except the minimum gap.
        min_gap_us = MIN_DT_RESET;
        for (int c = 0; c < NUM_CH; c++) begin
            est_position[c] = '0;
            est_stamp[c] = '0;
            est_sum[c] = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                est_history[c][i] = '0;
            end
        end

        // The directed table. Rows with a typed report were worked by hand
        // with the minimum gap at its reset value of 10 us.
        // A sample that equals the zero position just after reset changes
        // nothing on either channel.
        add_step(1'b0, 32'h0000_0000, 32'd5,         1'b1, 32'h0, 32'd0, 1'b0);
        add_step(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'd0, 1'b0);
        // The first real sample is taken against the zero position and stamp.
        add_step(1'b0, 32'h0001_0000, 32'd1000,      1'b0, 32'h0, 32'd0, 1'b0);
        // A full-scale jump in 11 us saturates high. The mean is a tenth of
        // the largest positive value.
        add_step(1'b1, 32'h7FFF_FFFF, 32'd11,        1'b1, 32'h7FFF_FFFF, 32'd214748364, 1'b1);
        // The swing to the most negative value saturates low. The sum drops
        // to -1 and the mean truncates to 0.
        add_step(1'b1, 32'h8000_0000, 32'd22,        1'b1, 32'h8000_0000, 32'd0, 1'b1);
        add_step(1'b1, 32'h8000_0000, 32'd100,       1'b1, 32'h8000_0000, 32'd0, 1'b0);
        // A short gap of 8 us moves the position but leaves the history alone.
        add_step(1'b1, 32'h0000_0005, 32'd30,        1'b1, 32'h0000_0005, 32'd0, 1'b1);
        // A gap equal to the minimum is still too short.
        add_step(1'b1, 32'h0000_0006, 32'd40,        1'b1, 32'h0000_0006, 32'd0, 1'b1);
        add_step(1'b1, 32'h0000_0007, 32'd51,        1'b0, 32'h0, 32'd0, 1'b0);
        // A very long forward gap, then a wrap of the stamp past zero, then
        // a stamp that goes backward and so looks like a huge gap.
        add_step(1'b0, 32'h0002_0000, 32'hFFFF_FFF0, 1'b0, 32'h0, 32'd0, 1'b0);
        add_step(1'b0, 32'h0003_0000, 32'h0000_0010, 1'b0, 32'h0, 32'd0, 1'b0);
        add_step(1'b0, 32'h0002_0000, 32'h0000_0005, 1'b0, 32'h0, 32'd0, 1'b0);
        add_step(1'b0, 32'hFFFF_FFFF, 32'h0000_1000, 1'b0, 32'h0, 32'd0, 1'b0);
        add_step(1'b0, 32'h7FFF_FFFF, 32'h0000_100B, 1'b0, 32'h0, 32'd0, 1'b0);
        add_step(1'b0, 32'h8000_0000, 32'h0000_1017, 1'b0, 32'h0, 32'd0, 1'b0);
        // Enough further rates on channel 0 to push the oldest entries out.
        for (int i = 1; i <= 8; i++) begin
            add_step(1'b0, 32'(i * 32'h0000_4000), 32'h0000_1017 + 32'(i * 100),
                     1'b0, 32'h0, 32'd0, 1'b0);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[i]) begin
            send_item(directed_steps[i].action, directed_steps[i].sample,
                      directed_steps[i].stamp, directed_steps[i].typed,
                      directed_steps[i].want);
        end

        // Random phases. Each phase has its own minimum gap: both extremes,
        // one, a random value and finally the reset value again.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: gap_setting = '0;
                1: gap_setting = '1;
                2: gap_setting = MIN_DT_W'(1);
                3: gap_setting = MIN_DT_W'($urandom_range(2, 65534));
                default: gap_setting = MIN_DT_RESET;
            endcase
            drain_reports();
            write_min_gap(gap_setting);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // A stretch of back-to-back traffic with no stalls.
                calm = (i >= 120 && i < 180);
                make_item(ch, smp, stamp);
                send_item(ch, smp, stamp, 1'b0, none);
            end
            calm = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
        end
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
